### src/cirb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration interface register package
// Register word offsets, bit constants and the response type shared by the
// register file and the top level.
// ----------------------------------------------------------------------------
package cirb_pkg;

	localparam logic [5:0] OFS_CONTROL   = 6'd0;
	localparam logic [5:0] OFS_LOCK      = 6'd1;
	localparam logic [5:0] OFS_CONFIG    = 6'd2;
	localparam logic [5:0] OFS_INT_STS   = 6'd3;
	localparam logic [5:0] OFS_INT_MASK  = 6'd4;
	localparam logic [5:0] OFS_STATUS    = 6'd5;
	localparam logic [5:0] OFS_DMA_SRC   = 6'd6;
	localparam logic [5:0] OFS_DMA_DST   = 6'd7;
	localparam logic [5:0] OFS_SRC_LEN   = 6'd8;
	localparam logic [5:0] OFS_DST_LEN   = 6'd9;
	localparam logic [5:0] OFS_SW_ID     = 6'd12;
	localparam logic [5:0] OFS_UNLOCK    = 6'd13;
	localparam logic [5:0] OFS_MISC_CTRL = 6'd32;

	localparam logic [31:0] UNLOCK_KEY   = 32'h757B_DF0D;
	localparam logic [31:0] CFG_RESET    = 32'h0000_050B;
	localparam logic [31:0] CFG_RSVD     = 32'hFFFF_F00F;
	localparam logic [31:0] ISTS_RSVD    = 32'h0708_0780;
	localparam logic [31:0] CTRL_RSVD    = 32'h107F_E000;
	localparam logic [31:0] CTRL_RESET   = 32'h0C00_6000;
	localparam logic [31:0] CTRL_UNLOCK  = 32'h0800_0E00;
	localparam logic [31:0] ISTS_RESET   = 32'h8802_0000;
	localparam logic [31:0] ISTS_DONE    = 32'h0000_3000;
	localparam logic [31:0] STATUS_VALUE = 32'h4000_0820;
	localparam logic [31:0] MCTRL_FIXED  = 32'h2080_0008;

	localparam int unsigned NUM_LOCKS = 5;
	localparam logic [31:0] LOCK_MASKS [NUM_LOCKS] = '{
		32'h0000_007F, 32'h0000_0080, 32'h0000_0100, 32'h0000_0E00, 32'h0000_1000
	};

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_level;
		logic        dma_issue;
		logic [31:0] dma_src_address;
		logic [31:0] dma_dst_address;
		logic [28:0] dma_src_bytes;
		logic [28:0] dma_dst_bytes;
		logic        dma_loopback;
	} rsp_t;

endpackage
`default_nettype wire

### src/cirb_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration interface register file
// Holds the register state, applies one request per cycle and forms the
// combinational response from the state after that request.
// ----------------------------------------------------------------------------
module cirb_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	input  wire logic         mode,
	input  wire logic [5:0]   word_offset,
	input  wire logic [31:0]  write_data,
	output cirb_pkg::rsp_t    rsp
);
	import cirb_pkg::*;

	logic [31:0] control_q, config_q, int_status_q, int_mask_q;
	logic [31:0] dma_source_q, dma_dest_q, software_id_q, unlock_q;
	logic [26:0] source_words_q, dest_words_q;
	logic [4:0]  lock_q;
	logic        loopback_q, access_q;

	logic [31:0] control_d, config_d, int_status_d, int_mask_d;
	logic [31:0] dma_source_d, dma_dest_d, software_id_d, unlock_d;
	logic [26:0] source_words_d, dest_words_d;
	logic [4:0]  lock_d;
	logic        loopback_d, access_d;
	logic [31:0] fixed_ctrl, rd;
	logic        issue, wr, rd_en;

	always_comb begin
		fixed_ctrl = CTRL_RSVD;
		for (int i = 0; i < NUM_LOCKS; i++) begin
			if (lock_q[i]) begin
				fixed_ctrl = fixed_ctrl | LOCK_MASKS[i];
			end
		end
	end

	always_comb begin
		control_d      = control_q;
		config_d       = config_q;
		int_status_d   = int_status_q;
		int_mask_d     = int_mask_q;
		dma_source_d   = dma_source_q;
		dma_dest_d     = dma_dest_q;
		software_id_d  = software_id_q;
		unlock_d       = unlock_q;
		source_words_d = source_words_q;
		dest_words_d   = dest_words_q;
		lock_d         = lock_q;
		loopback_d     = loopback_q;
		access_d       = access_q;
		issue          = 1'b0;
		wr             = req_valid & access_q & mode;
		rd_en          = req_valid & access_q & ~mode;
		rd             = '0;

		if (rd_en) begin
			unique case (word_offset)
				OFS_CONTROL:   rd = control_q;
				OFS_LOCK:      rd = {27'd0, lock_q};
				OFS_CONFIG:    rd = config_q;
				OFS_INT_STS:   rd = int_status_q;
				OFS_INT_MASK:  rd = int_mask_q;
				OFS_STATUS:    rd = STATUS_VALUE;
				OFS_DMA_SRC:   rd = dma_source_q;
				OFS_DMA_DST:   rd = dma_dest_q;
				OFS_SRC_LEN:   rd = {5'd0, source_words_q};
				OFS_DST_LEN:   rd = {5'd0, dest_words_q};
				OFS_SW_ID:     rd = software_id_q;
				OFS_UNLOCK:    rd = unlock_q;
				OFS_MISC_CTRL: rd = MCTRL_FIXED | {27'd0, loopback_q, 4'd0};
				default:       rd = '0;
			endcase
		end

		if (wr) begin
			unique case (word_offset)
				OFS_CONTROL:   control_d = (write_data & ~fixed_ctrl) | (control_q & fixed_ctrl);
				OFS_LOCK:      lock_d = lock_q | write_data[4:0];
				OFS_CONFIG:    config_d = (write_data & ~CFG_RSVD) | (config_q & CFG_RSVD);
				OFS_INT_STS:   int_status_d = int_status_q & ~(write_data & ~ISTS_RSVD);
				OFS_INT_MASK:  int_mask_d = (write_data & ~ISTS_RSVD) | (int_mask_q & ISTS_RSVD);
				OFS_DMA_SRC:   dma_source_d = write_data;
				OFS_DMA_DST:   dma_dest_d = write_data;
				OFS_SRC_LEN:   source_words_d = write_data[26:0];
				OFS_DST_LEN: begin
					dest_words_d = write_data[26:0];
					issue        = 1'b1;
					int_status_d = int_status_q | ISTS_DONE;
				end
				OFS_SW_ID:     software_id_d = write_data;
				OFS_UNLOCK: begin
					unlock_d = write_data;
					if (write_data == UNLOCK_KEY) begin
						control_d = control_q | CTRL_UNLOCK;
					end else begin
						control_d = control_q & ~CTRL_UNLOCK;
						access_d  = 1'b0;
					end
				end
				OFS_MISC_CTRL: loopback_d = write_data[4];
				default: ;
			endcase
		end

		rsp.read_data       = rd;
		rsp.irq_level       = |(~int_mask_d & int_status_d);
		rsp.dma_issue       = issue;
		rsp.dma_src_address = issue ? {dma_source_d[31:2], 2'b00} : '0;
		rsp.dma_dst_address = issue ? {dma_dest_d[31:2], 2'b00} : '0;
		rsp.dma_src_bytes   = issue ? {source_words_d, 2'b00} : '0;
		rsp.dma_dst_bytes   = issue ? {dest_words_d, 2'b00} : '0;
		rsp.dma_loopback    = issue & loopback_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q      <= CTRL_RESET;
			lock_q         <= '0;
			config_q       <= CFG_RESET;
			int_status_q   <= ISTS_RESET;
			int_mask_q     <= '1;
			dma_source_q   <= '0;
			dma_dest_q     <= '0;
			source_words_q <= '0;
			dest_words_q   <= '0;
			software_id_q  <= '0;
			unlock_q       <= '0;
			loopback_q     <= 1'b0;
			access_q       <= 1'b1;
		end else begin
			control_q      <= control_d;
			lock_q         <= lock_d;
			config_q       <= config_d;
			int_status_q   <= int_status_d;
			int_mask_q     <= int_mask_d;
			dma_source_q   <= dma_source_d;
			dma_dest_q     <= dma_dest_d;
			source_words_q <= source_words_d;
			dest_words_q   <= dest_words_d;
			software_id_q  <= software_id_d;
			unlock_q       <= unlock_d;
			loopback_q     <= loopback_d;
			access_q       <= access_d;
		end
	end

endmodule
`default_nettype wire

### src/config_interface_register_block.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration interface register block
// Bus register interface with lock, interrupt, unlock and DMA descriptor logic.
//
// A request is taken at each clock edge where start is high and busy is low.
// busy is always low, so one request can be given every cycle. Each request
// carries mode (0 read, 1 write), word_offset and write_data.
// The request is registered and applied to the register file at the next
// clock edge, where its response is registered as well. done is high for one
// cycle starting at that edge, together with the registered response, which
// carries read_data, irq_level and the DMA descriptor fields. Responses come
// back in request order, one per cycle.
// The receiver cannot stall; it must take each response in its done cycle.
// A write to the destination length register raises dma_issue with the
// descriptor; otherwise the descriptor fields are zero.
// The asynchronous reset returns the register file to its reset values and
// clears any request in flight. A bad unlock word blocks access until reset.
// ----------------------------------------------------------------------------
module config_interface_register_block (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        mode,
	input  wire logic [5:0]  word_offset,
	input  wire logic [31:0] write_data,
	output logic             done,
	output logic [31:0]      read_data,
	output logic             irq_level,
	output logic             dma_issue,
	output logic [31:0]      dma_src_address,
	output logic [31:0]      dma_dst_address,
	output logic [28:0]      dma_src_bytes,
	output logic [28:0]      dma_dst_bytes,
	output logic             dma_loopback
);
	import cirb_pkg::*;

	logic        req_valid_s1;
	logic        mode_s1;
	logic [5:0]  word_offset_s1;
	logic [31:0] write_data_s1;
	logic        done_q;
	rsp_t        rsp, rsp_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			req_valid_s1 <= start & ~busy;
			done_q       <= req_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1        <= mode;
		word_offset_s1 <= word_offset;
		write_data_s1  <= write_data;
		rsp_q          <= rsp;
	end

	cirb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid_s1),
		.mode        (mode_s1),
		.word_offset (word_offset_s1),
		.write_data  (write_data_s1),
		.rsp         (rsp)
	);

	assign done            = done_q;
	assign read_data       = rsp_q.read_data;
	assign irq_level       = rsp_q.irq_level;
	assign dma_issue       = rsp_q.dma_issue;
	assign dma_src_address = rsp_q.dma_src_address;
	assign dma_dst_address = rsp_q.dma_dst_address;
	assign dma_src_bytes   = rsp_q.dma_src_bytes;
	assign dma_dst_bytes   = rsp_q.dma_dst_bytes;
	assign dma_loopback    = rsp_q.dma_loopback;

endmodule
`default_nettype wire

### dv/cirb_register_monitor.sv
// ----------------------------------------------------------------------------
// Register access monitor
// Watches the request and response sides of the configuration interface
// register block. It keeps its own copy of the register state, works out the
// response of every accepted request, and compares each response, field by
// field, with the oldest one outstanding.
// ----------------------------------------------------------------------------
module cirb_register_monitor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic        mode,
	input  wire logic [5:0]  word_offset,
	input  wire logic [31:0] write_data,
	input  wire logic        done,
	input  wire logic [31:0] read_data,
	input  wire logic        irq_level,
	input  wire logic        dma_issue,
	input  wire logic [31:0] dma_src_address,
	input  wire logic [31:0] dma_dst_address,
	input  wire logic [28:0] dma_src_bytes,
	input  wire logic [28:0] dma_dst_bytes,
	input  wire logic        dma_loopback,
	output int unsigned      fail_count,
	output int unsigned      pending
);

	import cirb_pkg::*;

	logic [31:0] ctrl_q;
	logic [4:0]  lock_q;
	logic [31:0] cfg_q;
	logic [31:0] ists_q;
	logic [31:0] imask_q;
	logic [31:0] src_addr_q;
	logic [31:0] dst_addr_q;
	logic [26:0] src_len_q;
	logic [26:0] dst_len_q;
	logic [31:0] swid_q;
	logic [31:0] unlock_q;
	logic        loopback_q;
	logic        open_q;

	rsp_t        expected_rsp_q [$];
	rsp_t        want;
	int unsigned errors = 0;

	assign fail_count = errors;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		errors++;
		$display("%0t: mismatch on %s: got %h, expected %h",
			$time, what, got, exp_val);
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val) begin
			report_mismatch(what, got, exp_val);
		end
	endtask

	function automatic rsp_t apply_access(input logic wr, input logic [5:0] ofs,
			input logic [31:0] d);
		rsp_t        r;
		logic [31:0] nv;
		r = '0;
		if (open_q) begin
			if (!wr) begin
				case (ofs)
					OFS_CONTROL:   r.read_data = ctrl_q;
					OFS_LOCK:      r.read_data = {27'd0, lock_q};
					OFS_CONFIG:    r.read_data = cfg_q;
					OFS_INT_STS:   r.read_data = ists_q;
					OFS_INT_MASK:  r.read_data = imask_q;
					OFS_STATUS:    r.read_data = STATUS_VALUE;
					OFS_DMA_SRC:   r.read_data = src_addr_q;
					OFS_DMA_DST:   r.read_data = dst_addr_q;
					OFS_SRC_LEN:   r.read_data = {5'd0, src_len_q};
					OFS_DST_LEN:   r.read_data = {5'd0, dst_len_q};
					OFS_SW_ID:     r.read_data = swid_q;
					OFS_UNLOCK:    r.read_data = unlock_q;
					OFS_MISC_CTRL: r.read_data = MCTRL_FIXED | {27'd0, loopback_q, 4'd0};
					default:       r.read_data = '0;
				endcase
			end else begin
				case (ofs)
					OFS_CONTROL: begin
						nv = (d & ~CTRL_RSVD) | (ctrl_q & CTRL_RSVD);
						for (int i = 0; i < NUM_LOCKS; i++) begin
							if (lock_q[i]) begin
								nv = (nv & ~LOCK_MASKS[i]) | (ctrl_q & LOCK_MASKS[i]);
							end
						end
						ctrl_q = nv;
					end
					OFS_LOCK:     lock_q = lock_q | d[4:0];
					OFS_CONFIG:   cfg_q = (d & ~CFG_RSVD) | (cfg_q & CFG_RSVD);
					OFS_INT_STS:  ists_q = ists_q & ~(d & ~ISTS_RSVD);
					OFS_INT_MASK: imask_q = (d & ~ISTS_RSVD) | (imask_q & ISTS_RSVD);
					OFS_DMA_SRC:  src_addr_q = d;
					OFS_DMA_DST:  dst_addr_q = d;
					OFS_SRC_LEN:  src_len_q = d[26:0];
					OFS_DST_LEN: begin
						dst_len_q = d[26:0];
						ists_q = ists_q | ISTS_DONE;
						r.dma_issue = 1'b1;
					end
					OFS_SW_ID:    swid_q = d;
					OFS_UNLOCK: begin
						unlock_q = d;
						if (d == UNLOCK_KEY) begin
							ctrl_q = ctrl_q | CTRL_UNLOCK;
						end else begin
							ctrl_q = ctrl_q & ~CTRL_UNLOCK;
							open_q = 1'b0;
						end
					end
					OFS_MISC_CTRL: loopback_q = d[4];
					default: ;
				endcase
			end
		end
		r.irq_level = |(~imask_q & ists_q);
		if (r.dma_issue) begin
			r.dma_src_address = src_addr_q & 32'hFFFF_FFFC;
			r.dma_dst_address = dst_addr_q & 32'hFFFF_FFFC;
			r.dma_src_bytes   = {src_len_q, 2'b00};
			r.dma_dst_bytes   = {dst_len_q, 2'b00};
			r.dma_loopback    = loopback_q;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q     = CTRL_RESET;
			lock_q     = '0;
			cfg_q      = CFG_RESET;
			ists_q     = ISTS_RESET;
			imask_q    = '1;
			src_addr_q = '0;
			dst_addr_q = '0;
			src_len_q  = '0;
			dst_len_q  = '0;
			swid_q     = '0;
			unlock_q   = '0;
			loopback_q = 1'b0;
			open_q     = 1'b1;
			expected_rsp_q.delete();
			pending <= 0;
		end else begin
			if (done === 1'b1) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("response with no request outstanding", read_data, '0);
				end else begin
					want = expected_rsp_q.pop_front();
					check_field("read_data", read_data, want.read_data);
					check_field("irq_level", {31'd0, irq_level}, {31'd0, want.irq_level});
					check_field("dma_issue", {31'd0, dma_issue}, {31'd0, want.dma_issue});
					check_field("dma_src_address", dma_src_address, want.dma_src_address);
					check_field("dma_dst_address", dma_dst_address, want.dma_dst_address);
					check_field("dma_src_bytes", {3'd0, dma_src_bytes},
						{3'd0, want.dma_src_bytes});
					check_field("dma_dst_bytes", {3'd0, dma_dst_bytes},
						{3'd0, want.dma_dst_bytes});
					check_field("dma_loopback", {31'd0, dma_loopback},
						{31'd0, want.dma_loopback});
				end
			end
			if (start && !busy) begin
				expected_rsp_q.push_back(apply_access(mode, word_offset, write_data));
			end
			pending <= expected_rsp_q.size();
		end
	end

endmodule

### dv/config_interface_register_block_tb.sv
// ----------------------------------------------------------------------------
// Configuration interface register block testbench
// Drives a directed set of register accesses covering field extremes, locks,
// interrupt clearing, descriptor issue and unlock, then about eleven hundred
// random accesses with random gaps, and finally a bad unlock followed by
// blocked accesses. A monitor beside the block predicts and checks every
// response; this module gives the verdict.
// ----------------------------------------------------------------------------
module config_interface_register_block_tb;

	import cirb_pkg::*;

	localparam logic       ACC_READ       = 1'b0;
	localparam logic       ACC_WRITE      = 1'b1;
	localparam logic [5:0] OFS_ROM_SHADOW = 6'd10;
	localparam logic [5:0] OFS_UNMAPPED   = 6'd11;
	localparam logic [5:0] OFS_TOP_WORD   = 6'd63;
	localparam int unsigned RANDOM_ITEMS  = 1100;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        mode;
	logic [5:0]  word_offset;
	logic [31:0] write_data;
	logic        done;
	logic [31:0] read_data;
	logic        irq_level;
	logic        dma_issue;
	logic [31:0] dma_src_address;
	logic [31:0] dma_dst_address;
	logic [28:0] dma_src_bytes;
	logic [28:0] dma_dst_bytes;
	logic        dma_loopback;
	int unsigned fail_count;
	int unsigned pending;
	logic        no_gaps;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	config_interface_register_block u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.mode            (mode),
		.word_offset     (word_offset),
		.write_data      (write_data),
		.done            (done),
		.read_data       (read_data),
		.irq_level       (irq_level),
		.dma_issue       (dma_issue),
		.dma_src_address (dma_src_address),
		.dma_dst_address (dma_dst_address),
		.dma_src_bytes   (dma_src_bytes),
		.dma_dst_bytes   (dma_dst_bytes),
		.dma_loopback    (dma_loopback)
	);

	cirb_register_monitor u_register_monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.mode            (mode),
		.word_offset     (word_offset),
		.write_data      (write_data),
		.done            (done),
		.read_data       (read_data),
		.irq_level       (irq_level),
		.dma_issue       (dma_issue),
		.dma_src_address (dma_src_address),
		.dma_dst_address (dma_dst_address),
		.dma_src_bytes   (dma_src_bytes),
		.dma_dst_bytes   (dma_dst_bytes),
		.dma_loopback    (dma_loopback),
		.fail_count      (fail_count),
		.pending         (pending)
	);

	// Called right after a rising edge; returns right after the edge that
	// accepted the request.
	task automatic send_request(input logic wr, input logic [5:0] ofs, input logic [31:0] d);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		mode        <= wr;
		word_offset <= ofs;
		write_data  <= d;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		int unsigned i;
		logic        wr;
		logic [5:0]  ofs;
		logic [31:0] d;

		arst_n      = 1'b0;
		start       = 1'b0;
		mode        = ACC_READ;
		word_offset = '0;
		write_data  = '0;
		no_gaps     = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(ACC_READ, OFS_CONTROL, $urandom);
		send_request(ACC_READ, OFS_STATUS, $urandom);
		send_request(ACC_READ, OFS_ROM_SHADOW, $urandom);
		send_request(ACC_READ, OFS_MISC_CTRL, $urandom);
		send_request(ACC_READ, OFS_TOP_WORD, $urandom);
		send_request(ACC_WRITE, OFS_CONTROL, 32'hFFFF_FFFF);
		send_request(ACC_WRITE, OFS_CONTROL, 32'h0);
		send_request(ACC_WRITE, OFS_INT_MASK, 32'h0);
		send_request(ACC_WRITE, OFS_INT_STS, 32'hFFFF_FFFF);
		send_request(ACC_WRITE, OFS_INT_MASK, 32'hFFFF_FFFF);
		send_request(ACC_WRITE, OFS_CONFIG, 32'hFFFF_FFFF);
		send_request(ACC_WRITE, OFS_CONFIG, 32'h0);
		send_request(ACC_WRITE, OFS_DMA_SRC, 32'hFFFF_FFFF);
		send_request(ACC_WRITE, OFS_DMA_DST, 32'hFFFF_FFFF);
		send_request(ACC_WRITE, OFS_SRC_LEN, 32'hFFFF_FFFF);
		send_request(ACC_WRITE, OFS_MISC_CTRL, 32'hFFFF_FFFF);
		send_request(ACC_WRITE, OFS_DST_LEN, 32'hFFFF_FFFF);
		send_request(ACC_WRITE, OFS_MISC_CTRL, 32'h0);
		send_request(ACC_WRITE, OFS_DST_LEN, 32'h0);
		send_request(ACC_WRITE, OFS_TOP_WORD, 32'hFFFF_FFFF);
		send_request(ACC_WRITE, OFS_STATUS, 32'hFFFF_FFFF);
		send_request(ACC_WRITE, OFS_SW_ID, 32'hFFFF_FFFF);
		send_request(ACC_WRITE, OFS_UNLOCK, UNLOCK_KEY);
		send_request(ACC_WRITE, OFS_LOCK, 32'h0);
		send_request(ACC_READ, OFS_INT_STS, $urandom);

		// Lock bits are sticky, so they are only set in the second half to
		// leave the control fields free for most of the run.
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0) begin
				no_gaps = ($urandom_range(0, 2) == 0);
			end
			wr = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 15))
				0:       ofs = OFS_CONTROL;
				1:       ofs = OFS_LOCK;
				2:       ofs = OFS_CONFIG;
				3:       ofs = OFS_INT_STS;
				4:       ofs = OFS_INT_MASK;
				5:       ofs = OFS_STATUS;
				6:       ofs = OFS_DMA_SRC;
				7:       ofs = OFS_DMA_DST;
				8:       ofs = OFS_SRC_LEN;
				9:       ofs = OFS_DST_LEN;
				10:      ofs = OFS_ROM_SHADOW;
				11:      ofs = OFS_SW_ID;
				12:      ofs = OFS_UNLOCK;
				13:      ofs = OFS_MISC_CTRL;
				default: ofs = 6'($urandom_range(0, 63));
			endcase
			d = $urandom;
			if ($urandom_range(0, 3) == 0) begin
				d = 32'h1 << $urandom_range(0, 31);
			end
			if (wr == ACC_WRITE && ofs == OFS_UNLOCK) begin
				d = UNLOCK_KEY;
			end
			if (wr == ACC_WRITE && ofs == OFS_LOCK) begin
				if (i < RANDOM_ITEMS / 2 || $urandom_range(0, 3) != 0) begin
					wr = ACC_READ;
				end else begin
					d = ($urandom & 32'hFFFF_FFE0) | (32'h1 << $urandom_range(0, 4));
				end
			end
			send_request(wr, ofs, d);
		end

		// A bad unlock word blocks every later access until reset.
		no_gaps = 1'b0;
		send_request(ACC_WRITE, OFS_UNLOCK, UNLOCK_KEY ^ ($urandom | 32'h1));
		send_request(ACC_READ, OFS_CONTROL, $urandom);
		send_request(ACC_WRITE, OFS_DST_LEN, $urandom);
		send_request(ACC_READ, OFS_UNLOCK, $urandom);
		send_request(ACC_WRITE, OFS_UNLOCK, UNLOCK_KEY);
		send_request(ACC_READ, OFS_MISC_CTRL, $urandom);
		start <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
